// File: hdl/pog_pkg.sv
package pog_pkg;

  // Default width of the running averages (fraction bits)
  localparam int AVG_FRAC_BITS_DEF = 32;

  // Raw energies are compared over this many low bits
  localparam int ENERGY_BITS   = 32;
  localparam int ENERGY_W      = 32;
  localparam int ENERGY_CMP_W  = (ENERGY_BITS < ENERGY_W) ? ENERGY_BITS : ENERGY_W;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  localparam logic [CFG_IDX_W-1:0] CFG_ADAPT_RATE     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_REFRACTORY_US  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD_CAP  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DEV_MULTIPLIER = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_PEAK_FLOOR     = 3'd4;

  localparam logic [15:0] ADAPT_RATE_RST     = 16'd1311;
  localparam logic [23:0] REFRACTORY_US_RST  = 24'd90000;
  localparam logic [15:0] THRESHOLD_CAP_RST  = 16'd29491;
  localparam logic [3:0]  DEV_MULTIPLIER_RST = 4'd7;
  localparam logic [15:0] PEAK_FLOOR_RST     = 16'd0;

  localparam logic [1:0] CLS_KICK  = 2'd0;
  localparam logic [1:0] CLS_SNARE = 2'd1;
  localparam logic [1:0] CLS_HIHAT = 2'd2;

  localparam logic [15:0] CONF_MAX = 16'hFFFF;

  typedef struct packed {
    logic [15:0] adapt_rate;
    logic [23:0] refractory_us;
    logic [15:0] threshold_cap;
    logic [3:0]  dev_multiplier;
    logic [15:0] peak_floor;
  } cfg_t;

  typedef struct packed {
    logic [15:0]         band_low;
    logic [15:0]         band_mid;
    logic [15:0]         band_high;
    logic [ENERGY_W-1:0] energy_low;
    logic [ENERGY_W-1:0] energy_mid;
    logic [ENERGY_W-1:0] energy_high;
    logic [31:0]         timestamp_us;
  } in_word_t;

  typedef struct packed {
    logic [1:0]  event_class;
    logic [31:0] event_time_us;
    logic [15:0] confidence;
    logic [15:0] strength;
  } out_word_t;

  // Controller to datapath
  typedef struct packed {
    logic load;
    logic prep;
    logic thr;
    logic eval;
    logic step;
    logic commit;
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic fire;
  } dp_sts_t;

endpackage

// File: hdl/pog_stream_if.sv
interface pog_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: hdl/percussion_onset_gate.sv
// channel  dir  word         handshake
// in_if    in   in_word_t    valid/ready, taken when both high
// out_if   out  out_word_t   valid/ready, zero or one word per hop
// cfg      in   index, data  cfg_we_i, one register per edge
//
// One hop holds the block from the accepting cycle through three setup steps,
// 16 steps of the shared iteration loop that forms both average updates and the
// confidence quotient one bit per cycle, and one commit step; the next word can be
// taken in the cycle after commit.
// A firing hop waits in its commit step while the previous word is untaken.
// rst_ni clears the averages, refractory history and handshake; config gets its defaults.
module percussion_onset_gate
  import pog_pkg::*;
#(
  parameter int AVG_FRAC_BITS = AVG_FRAC_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  pog_stream_if.sink            in_if,
  pog_stream_if.source          out_if,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  cfg_t      cfg;
  dp_cmd_t   cmd;
  dp_sts_t   sts;
  out_word_t out_word;

  pog_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  pog_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_if.valid),
    .in_ready_o  (in_if.ready),
    .out_valid_o (out_if.valid),
    .out_ready_i (out_if.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  pog_dp #(
    .AVG_FRAC_BITS (AVG_FRAC_BITS)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg),
    .cmd_i      (cmd),
    .in_word_i  (in_if.data),
    .sts_o      (sts),
    .out_word_o (out_word)
  );

  assign out_if.data = out_word;

endmodule

// File: hdl/pog_cfg.sv
module pog_cfg
  import pog_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output cfg_t                  cfg_o
);

  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.adapt_rate     <= ADAPT_RATE_RST;
      cfg_q.refractory_us  <= REFRACTORY_US_RST;
      cfg_q.threshold_cap  <= THRESHOLD_CAP_RST;
      cfg_q.dev_multiplier <= DEV_MULTIPLIER_RST;
      cfg_q.peak_floor     <= PEAK_FLOOR_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_ADAPT_RATE:     cfg_q.adapt_rate     <= cfg_data_i[15:0];
        CFG_REFRACTORY_US:  cfg_q.refractory_us  <= cfg_data_i[23:0];
        CFG_THRESHOLD_CAP:  cfg_q.threshold_cap  <= cfg_data_i[15:0];
        CFG_DEV_MULTIPLIER: cfg_q.dev_multiplier <= cfg_data_i[3:0];
        CFG_PEAK_FLOOR:     cfg_q.peak_floor     <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

// File: hdl/pog_ctrl.sv
module pog_ctrl
  import pog_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  input  dp_sts_t sts_i,
  output dp_cmd_t cmd_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_THR,
    ST_EVAL,
    ST_ITER,
    ST_DONE
  } state_e;

  state_e      state_q;
  logic [3:0]  cnt_q;
  logic        out_valid_q;
  logic        commit;

  // a firing word waits until the output register is free
  assign commit = (state_q == ST_DONE) && (!sts_i.fire || !out_valid_q || out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (commit && sts_i.fire) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_valid_i) state_q <= ST_PREP;
        end
        ST_PREP: state_q <= ST_THR;
        ST_THR:  state_q <= ST_EVAL;
        ST_EVAL: begin
          cnt_q   <= '0;
          state_q <= ST_ITER;
        end
        ST_ITER: begin
          cnt_q <= cnt_q + 4'd1;
          if (cnt_q == 4'd15) state_q <= ST_DONE;
        end
        ST_DONE: begin
          if (commit) state_q <= ST_IDLE;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // no word is taken while reset is held
  assign in_ready_o  = rst_ni && (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    cmd_o        = '0;
    cmd_o.load   = in_ready_o && in_valid_i;
    cmd_o.prep   = (state_q == ST_PREP);
    cmd_o.thr    = (state_q == ST_THR);
    cmd_o.eval   = (state_q == ST_EVAL);
    cmd_o.step   = (state_q == ST_ITER);
    cmd_o.commit = commit;
  end

endmodule

// File: hdl/pog_dp.sv
module pog_dp
  import pog_pkg::*;
#(
  parameter int AVG_FRAC_BITS = AVG_FRAC_BITS_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  cfg_t      cfg_i,
  input  dp_cmd_t   cmd_i,
  input  in_word_t  in_word_i,
  output dp_sts_t   sts_o,
  output out_word_t out_word_o
);

  localparam int F  = AVG_FRAC_BITS;
  localparam int UP = F - 16;

  // per-hop registers
  logic [15:0]  peak_q;
  logic [1:0]   cls_q;
  logic [31:0]  time_q;
  logic [F-1:0] mdiff_q;
  logic         mup_q;
  logic [F+3:0] md_q;
  logic [F-1:0] thr_q;
  logic         fire_q;
  logic         thr_zero_q;
  logic         sat_q;
  logic [F-1:0] ddiff_q;
  logic         dup_q;
  logic [15:0]  rate_q;
  logic [F-1:0] hm_q;
  logic [F-1:0] hd_q;
  logic [F-1:0] rem_q;
  logic [15:0]  quo_q;

  // state kept across hops
  logic [F-1:0] mean_q;
  logic [F-1:0] dev_q;
  logic [31:0]  last_q;
  logic         fired_q;

  out_word_t    out_q;

  logic [15:0]  peak;
  logic [1:0]   cls;
  logic [F-1:0] peak_f;
  logic [F-1:0] cap_f;
  logic [F+4:0] thr_sum;
  logic [31:0]  since;
  logic [F-1:0] diff;
  logic [F:0]   hm_sum;
  logic [F:0]   hd_sum;
  logic [F:0]   rem2;
  logic         take;
  logic [15:0]  conf;

  logic [ENERGY_CMP_W-1:0] e_low, e_mid, e_high;

  assign e_low  = in_word_i.energy_low[ENERGY_CMP_W-1:0];
  assign e_mid  = in_word_i.energy_mid[ENERGY_CMP_W-1:0];
  assign e_high = in_word_i.energy_high[ENERGY_CMP_W-1:0];

  always_comb begin
    peak = in_word_i.band_low;
    if (in_word_i.band_mid > peak)  peak = in_word_i.band_mid;
    if (in_word_i.band_high > peak) peak = in_word_i.band_high;
    // first band wins ties
    cls = CLS_KICK;
    if (e_mid > e_low) cls = CLS_SNARE;
    if (cls == CLS_SNARE) begin
      if (e_high > e_mid) cls = CLS_HIHAT;
    end else begin
      if (e_high > e_low) cls = CLS_HIHAT;
    end
  end

  assign peak_f  = F'(peak_q) << UP;
  assign cap_f   = F'(cfg_i.threshold_cap) << UP;
  assign thr_sum = (F+5)'(mean_q) + (F+5)'(md_q);
  assign since   = time_q - last_q;
  assign diff    = peak_f - thr_q;

  // shift-add products, truncated by 16 bits after the last step
  assign hm_sum = (F+1)'(hm_q) + (rate_q[0] ? (F+1)'(mdiff_q) : '0);
  assign hd_sum = (F+1)'(hd_q) + (rate_q[0] ? (F+1)'(ddiff_q) : '0);

  // restoring divide of diff * 2^16 by thr, remainder stays below thr
  assign rem2 = {rem_q, 1'b0};
  assign take = (rem2 >= (F+1)'(thr_q));

  always_comb begin
    if (thr_zero_q)  conf = peak_q;
    else if (sat_q)  conf = CONF_MAX;
    else             conf = quo_q;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      peak_q <= peak;
      cls_q  <= cls;
      time_q <= in_word_i.timestamp_us;
    end
    if (cmd_i.prep) begin
      md_q    <= (F+4)'(dev_q) * (F+4)'(cfg_i.dev_multiplier);
      mup_q   <= (peak_f >= mean_q);
      mdiff_q <= (peak_f >= mean_q) ? peak_f - mean_q : mean_q - peak_f;
    end
    if (cmd_i.thr) begin
      thr_q <= (thr_sum > (F+5)'(cap_f)) ? cap_f : thr_sum[F-1:0];
      dup_q   <= (mdiff_q >= dev_q);
      ddiff_q <= (mdiff_q >= dev_q) ? mdiff_q - dev_q : dev_q - mdiff_q;
    end
    if (cmd_i.eval) begin
      fire_q     <= (peak_f > thr_q) && (peak_q > cfg_i.peak_floor) &&
                    (!fired_q || (since >= {8'd0, cfg_i.refractory_us}));
      thr_zero_q <= (thr_q == '0);
      sat_q      <= (diff >= thr_q);
      rem_q      <= diff;
      quo_q      <= '0;
      rate_q     <= cfg_i.adapt_rate;
      hm_q       <= '0;
      hd_q       <= '0;
    end
    if (cmd_i.step) begin
      hm_q   <= hm_sum[F:1];
      hd_q   <= hd_sum[F:1];
      rate_q <= rate_q >> 1;
      rem_q  <= take ? F'(rem2 - (F+1)'(thr_q)) : rem2[F-1:0];
      quo_q  <= {quo_q[14:0], take};
    end
    if (cmd_i.commit && fire_q) begin
      out_q.event_class   <= cls_q;
      out_q.event_time_us <= time_q;
      out_q.confidence    <= conf;
      out_q.strength      <= peak_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mean_q  <= '0;
      dev_q   <= '0;
      last_q  <= '0;
      fired_q <= 1'b0;
    end else if (cmd_i.commit) begin
      mean_q <= mup_q ? mean_q + hm_q : mean_q - hm_q;
      dev_q  <= dup_q ? dev_q + hd_q : dev_q - hd_q;
      if (fire_q) begin
        last_q  <= time_q;
        fired_q <= 1'b1;
      end
    end
  end

  assign sts_o.fire = fire_q;
  assign out_word_o = out_q;

endmodule

// File: dv/percussion_onset_gate_test.sv
module percussion_onset_gate_test;
  import pog_pkg::*;

  localparam int AVG_FB         = AVG_FRAC_BITS_DEF;
  localparam int UP_SHIFT       = AVG_FB - 16;
  localparam int SETTLE_CYCLES  = 64;
  localparam int HOLD_CYCLES    = 400;
  localparam int STALL_LIMIT    = 4000;
  localparam int PHASES         = 9;
  localparam int HOPS_PER_PHASE = 200;
  localparam int FLOOD_HOPS     = 16;

  // indexes past the last register; writes there must be dropped
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

  typedef enum logic [1:0] {
    BY_MODEL,
    NO_EVENT,
    EVENT_AS_LISTED
  } row_check_e;

  typedef struct packed {
    logic [15:0] lo;
    logic [15:0] mid;
    logic [15:0] hi;
    logic [31:0] e_lo;
    logic [31:0] e_mid;
    logic [31:0] e_hi;
    logic [31:0] ts;
    row_check_e  chk;
    logic [1:0]  cls;
    logic [15:0] conf;
    logic [15:0] strength;
  } plan_row_t;

  // Run under reset settings; history starts empty, so threshold is zero at first.
  localparam plan_row_t PLAN [18] = '{
    '{16'h0000, 16'h0000, 16'h0000, 32'h0, 32'h0, 32'h0, 32'd0,
      NO_EVENT, CLS_KICK, 16'h0, 16'h0},
    // first event: zero threshold gives confidence = peak, tie goes to low band
    '{16'hFFFF, 16'h0000, 16'h0000, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'd1000,
      EVENT_AS_LISTED, CLS_KICK, 16'hFFFF, 16'hFFFF},
    // one microsecond short of the refractory time
    '{16'h0000, 16'h0000, 16'hFFFF, 32'h0, 32'h0, 32'hFFFFFFFF, 32'd90999,
      NO_EVENT, CLS_KICK, 16'h0, 16'h0},
    '{16'h0000, 16'hFFFF, 16'h0000, 32'h0, 32'hFFFFFFFF, 32'h0, 32'd91000,
      BY_MODEL, CLS_KICK, 16'h0, 16'h0},
    '{16'h0000, 16'h0000, 16'h0000, 32'd1, 32'd2, 32'd3, 32'd200000,
      NO_EVENT, CLS_KICK, 16'h0, 16'h0},
    '{16'h0000, 16'h0000, 16'h8000, 32'h0, 32'h0, 32'd1, 32'd400000,
      BY_MODEL, CLS_KICK, 16'h0, 16'h0},
    '{16'h1234, 16'h8000, 16'h0000, 32'h0, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'd600000,
      BY_MODEL, CLS_KICK, 16'h0, 16'h0},
    '{16'hC000, 16'hC000, 16'hC000, 32'h0, 32'h0, 32'h0, 32'd800000,
      BY_MODEL, CLS_KICK, 16'h0, 16'h0},
    '{16'h0001, 16'h0000, 16'h0000, 32'd5, 32'd4, 32'd3, 32'd1000000,
      BY_MODEL, CLS_KICK, 16'h0, 16'h0},
    '{16'h0000, 16'h0000, 16'hFFFF, 32'd10, 32'd20, 32'd30, 32'hFFFFFFF0,
      BY_MODEL, CLS_KICK, 16'h0, 16'h0},
    // timestamp wrapped past zero
    '{16'hFFFF, 16'h0000, 16'h0000, 32'd7, 32'd7, 32'd7, 32'h00015F80,
      BY_MODEL, CLS_KICK, 16'h0, 16'h0},
    '{16'hFFFF, 16'hFFFF, 16'hFFFF, 32'd1, 32'd0, 32'd1, 32'h00015F8A,
      NO_EVENT, CLS_KICK, 16'h0, 16'h0},
    '{16'h7000, 16'h0000, 16'h0000, 32'h80000000, 32'h7FFFFFFF, 32'h0, 32'h00040000,
      BY_MODEL, CLS_KICK, 16'h0, 16'h0},
    '{16'h0000, 16'h5000, 16'h0000, 32'h0000FFFF, 32'h00010000, 32'h0, 32'h00060000,
      BY_MODEL, CLS_KICK, 16'h0, 16'h0},
    '{16'h0000, 16'h0000, 16'h4000, 32'h55555555, 32'hAAAAAAAA, 32'hAAAAAAAB,
      32'h00080000, BY_MODEL, CLS_KICK, 16'h0, 16'h0},
    '{16'h3000, 16'h0000, 16'h0000, 32'h1, 32'h1, 32'h0, 32'h000A0000,
      BY_MODEL, CLS_KICK, 16'h0, 16'h0},
    '{16'h2000, 16'h2000, 16'h0000, 32'h0, 32'h0, 32'h1, 32'h000C0000,
      BY_MODEL, CLS_KICK, 16'h0, 16'h0},
    '{16'hFFFF, 16'hFFFF, 16'hFFFF, 32'hFFFFFFFF, 32'h0, 32'hFFFFFFFF, 32'h000E0000,
      BY_MODEL, CLS_KICK, 16'h0, 16'h0}
  };

  localparam cfg_t GATE_MODES [7] = '{
    '{ADAPT_RATE_RST, REFRACTORY_US_RST, THRESHOLD_CAP_RST, DEV_MULTIPLIER_RST,
      PEAK_FLOOR_RST},
    '{16'd65535, 24'd0, 16'd65535, 4'd15, 16'd0},
    // floor at max: nothing can fire
    '{16'd1, 24'd10000000, 16'd0, 4'd1, 16'd65535},
    // zero cap: threshold always zero
    '{16'd3000, 24'd20000, 16'd0, 4'd4, 16'd0},
    // frozen averages, bare mean as threshold
    '{16'd0, 24'd50000, 16'd40000, 4'd0, 16'd12000},
    '{16'd655, 24'd120000, 16'd20000, 4'd3, 16'd30000},
    '{16'd8000, 24'd16777215, 16'd50000, 4'd2, 16'd100}
  };

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  pog_stream_if #(.T(in_word_t))  hop_if ();
  pog_stream_if #(.T(out_word_t)) event_if ();

  percussion_onset_gate uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_if      (hop_if),
    .out_if     (event_if),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  // predictor state
  cfg_t              gate_cfg;
  logic [AVG_FB-1:0] avg_level;
  logic [AVG_FB-1:0] avg_spread;
  logic [31:0]       last_hit_us;
  bit                hit_seen;

  out_word_t   pending_events [$];
  int unsigned fault_count = 0;
  int unsigned idle_cycles = 0;
  int unsigned burst_left;
  logic [31:0] clock_us;
  bit          src_on;
  bit          hold_req;
  bit          hold_active;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  task automatic log_fault(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
    fault_count++;
  endtask

  task automatic stash_event(input out_word_t ev);
    pending_events = {pending_events, ev};
  endtask

  // one averaging step, magnitude of the move truncated
  function automatic logic [AVG_FB-1:0] glide(input logic [AVG_FB-1:0] avg,
                                               input logic [63:0] goal,
                                               input logic [15:0] gain);
    logic [63:0]       nudge;
    logic [AVG_FB-1:0] moved;
    if (goal >= 64'(avg)) begin
      nudge = ((goal - 64'(avg)) * 64'(gain)) >> 16;
      moved = avg + nudge[AVG_FB-1:0];
    end else begin
      nudge = ((64'(avg) - goal) * 64'(gain)) >> 16;
      moved = avg - nudge[AVG_FB-1:0];
    end
    return moved;
  endfunction

  function automatic bit forecast_hop(input in_word_t w, output out_word_t ev);
    logic [15:0]             peak;
    logic [63:0]             peak_q, limit, cap_q, over, ratio, spread;
    logic [31:0]             since;
    logic [ENERGY_CMP_W-1:0] loudest;
    bit                      fire;
    peak = w.band_low;
    if (w.band_mid > peak) peak = w.band_mid;
    if (w.band_high > peak) peak = w.band_high;
    peak_q = 64'(peak) << UP_SHIFT;
    limit  = 64'(avg_level) + 64'(gate_cfg.dev_multiplier) * 64'(avg_spread);
    cap_q  = 64'(gate_cfg.threshold_cap) << UP_SHIFT;
    if (cap_q < limit) limit = cap_q;
    since = w.timestamp_us - last_hit_us;
    fire = (peak_q > limit) && (peak > gate_cfg.peak_floor) &&
           (!hit_seen || since >= 32'(gate_cfg.refractory_us));
    ev = '0;
    if (fire) begin
      ev.event_class = CLS_KICK;
      loudest = w.energy_low[ENERGY_CMP_W-1:0];
      if (w.energy_mid[ENERGY_CMP_W-1:0] > loudest) begin
        ev.event_class = CLS_SNARE;
        loudest = w.energy_mid[ENERGY_CMP_W-1:0];
      end
      if (w.energy_high[ENERGY_CMP_W-1:0] > loudest) ev.event_class = CLS_HIHAT;
      if (limit == 0) begin
        ev.confidence = peak;
      end else begin
        over = peak_q - limit;
        if (over >= limit) begin
          ev.confidence = CONF_MAX;
        end else begin
          ratio = (over << 16) / limit;
          ev.confidence = (ratio > 64'(CONF_MAX)) ? CONF_MAX : ratio[15:0];
        end
      end
      ev.event_time_us = w.timestamp_us;
      ev.strength      = peak;
      last_hit_us      = w.timestamp_us;
      hit_seen         = 1'b1;
    end
    // deviation is taken against the mean before this hop moves it
    spread = (peak_q >= 64'(avg_level)) ? peak_q - 64'(avg_level) : 64'(avg_level) - peak_q;
    avg_level  = glide(avg_level, peak_q, gate_cfg.adapt_rate);
    avg_spread = glide(avg_spread, 64'(spread[AVG_FB-1:0]), gate_cfg.adapt_rate);
    return fire;
  endfunction

  // mostly quiet hops with sporadic spikes, some fully random
  function automatic in_word_t make_hop();
    in_word_t    w;
    int unsigned kind;
    logic [15:0] spike;
    kind = $urandom_range(0, 99);
    w.band_low  = 16'($urandom_range(0, 6000));
    w.band_mid  = 16'($urandom_range(0, 6000));
    w.band_high = 16'($urandom_range(0, 6000));
    if (kind >= 90) begin
      w.band_low  = 16'($urandom);
      w.band_mid  = 16'($urandom);
      w.band_high = 16'($urandom);
    end else if (kind >= 60) begin
      spike = 16'($urandom_range(20000, 65535));
      case ($urandom_range(0, 2))
        0:       w.band_low  = spike;
        1:       w.band_mid  = spike;
        default: w.band_high = spike;
      endcase
    end
    w.energy_low  = $urandom;
    w.energy_mid  = $urandom;
    w.energy_high = $urandom;
    case ($urandom_range(0, 19))
      0:       w.energy_mid  = w.energy_low;
      1:       w.energy_high = w.energy_low;
      2:       w.energy_high = w.energy_mid;
      3:       w.energy_low  = '0;
      4:       w.energy_mid  = '1;
      default: ;
    endcase
    kind = $urandom_range(0, 19);
    if (kind == 0) clock_us = $urandom;
    else if (kind < 3) clock_us += $urandom_range(0, 2000);
    else clock_us += $urandom_range(5000, 60000);
    w.timestamp_us = clock_us;
    return w;
  endfunction

  task automatic offer_hop(input in_word_t w);
    hop_if.valid <= 1'b1;
    hop_if.data  <= w;
    src_on = 1'b1;
    do @(posedge clk_i); while (hop_if.ready !== 1'b1);
  endtask

  task automatic pace();
    int unsigned gap;
    if (burst_left != 0) begin
      burst_left--;
    end else begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
      if (gap != 0) begin
        hop_if.valid <= 1'b0;
        src_on = 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(0, 24);
    end
  endtask

  // hops that fire nothing may still be in flight once the queue is empty
  task automatic settle();
    if (src_on) begin
      hop_if.valid <= 1'b0;
      src_on = 1'b0;
    end
    while (pending_events.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic poke_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    case (idx)
      CFG_ADAPT_RATE:     gate_cfg.adapt_rate     = val[15:0];
      CFG_REFRACTORY_US:  gate_cfg.refractory_us  = val[23:0];
      CFG_THRESHOLD_CAP:  gate_cfg.threshold_cap  = val[15:0];
      CFG_DEV_MULTIPLIER: gate_cfg.dev_multiplier = val[3:0];
      CFG_PEAK_FLOOR:     gate_cfg.peak_floor     = val[15:0];
      default: ;
    endcase
  endtask

  // junk above each narrower register's width must be masked off
  task automatic program_gate(input cfg_t m);
    poke_reg(CFG_ADAPT_RATE, {8'($urandom), m.adapt_rate});
    poke_reg(CFG_REFRACTORY_US, m.refractory_us);
    poke_reg(CFG_THRESHOLD_CAP, {8'($urandom), m.threshold_cap});
    poke_reg(CFG_DEV_MULTIPLIER, {20'($urandom), m.dev_multiplier});
    poke_reg(CFG_PEAK_FLOOR, {8'($urandom), m.peak_floor});
    poke_reg(3'($urandom_range(CFG_SPARE_LO, CFG_SPARE_HI)), 24'($urandom));
    cfg_we_i <= 1'b0;
  endtask

  initial begin : hop_source
    in_word_t  hop;
    out_word_t ev;
    cfg_t      mode;
    int        i, p, n;
    rst_ni       = 1'b0;
    cfg_we_i     = 1'b0;
    cfg_idx_i    = '0;
    cfg_data_i   = '0;
    hop_if.valid = 1'b0;
    hop_if.data  = '0;
    gate_cfg     = GATE_MODES[0];
    avg_level    = '0;
    avg_spread   = '0;
    last_hit_us  = '0;
    hit_seen     = 1'b0;
    burst_left   = 0;
    src_on       = 1'b0;
    hold_req     = 1'b0;
    clock_us     = 32'h00100000;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (i = 0; i < $size(PLAN); i++) begin
      hop.band_low     = PLAN[i].lo;
      hop.band_mid     = PLAN[i].mid;
      hop.band_high    = PLAN[i].hi;
      hop.energy_low   = PLAN[i].e_lo;
      hop.energy_mid   = PLAN[i].e_mid;
      hop.energy_high  = PLAN[i].e_hi;
      hop.timestamp_us = PLAN[i].ts;
      offer_hop(hop);
      // predictor runs on every row so its history stays in step
      if (forecast_hop(hop, ev) && PLAN[i].chk == BY_MODEL) stash_event(ev);
      if (PLAN[i].chk == EVENT_AS_LISTED) begin
        ev.event_class   = PLAN[i].cls;
        ev.event_time_us = PLAN[i].ts;
        ev.confidence    = PLAN[i].conf;
        ev.strength      = PLAN[i].strength;
        stash_event(ev);
      end
      pace();
    end
    settle();

    // output held off while firing hops keep coming: the block must back up
    hold_req = 1'b1;
    while (!hold_active) @(posedge clk_i);
    hold_req = 1'b0;
    for (n = 0; n < FLOOD_HOPS; n++) begin
      hop = make_hop();
      clock_us += 200000;
      hop.timestamp_us = clock_us;
      hop.band_high    = 16'hFFFF;
      offer_hop(hop);
      if (forecast_hop(hop, ev)) stash_event(ev);
    end
    settle();

    for (p = 0; p < PHASES; p++) begin
      if (p < $size(GATE_MODES)) begin
        mode = GATE_MODES[p];
      end else begin
        mode.adapt_rate     = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(1, 65535))
                                                          : 16'($urandom_range(200, 4000));
        mode.refractory_us  = 24'($urandom_range(0, 200000));
        mode.threshold_cap  = 16'($urandom_range(8000, 65535));
        mode.dev_multiplier = 4'($urandom_range(0, 15));
        mode.peak_floor     = 16'($urandom_range(0, 30000));
      end
      program_gate(mode);
      for (n = 0; n < HOPS_PER_PHASE; n++) begin
        hop = make_hop();
        offer_hop(hop);
        if (forecast_hop(hop, ev)) stash_event(ev);
        pace();
      end
      settle();
    end

    if (fault_count == 0) begin
      $display("percussion_onset_gate_test passed");
    end else begin
      $display("percussion_onset_gate_test failed");
    end
    $finish;
  end

  initial begin : event_sink
    int unsigned mode, span, k;
    event_if.ready = 1'b0;
    hold_active    = 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (hold_req) begin
        event_if.ready <= 1'b0;
        hold_active = 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_active = 1'b0;
      end
      mode = $urandom_range(0, 3);
      span = $urandom_range(4, 120);
      for (k = 0; k < span && !hold_req; k++) begin
        case (mode)
          0:       event_if.ready <= 1'b1;
          1:       event_if.ready <= ($urandom_range(0, 3) != 0);
          2:       event_if.ready <= 1'($urandom_range(0, 1));
          default: event_if.ready <= ((k % 7) < 2);
        endcase
        @(posedge clk_i);
      end
    end
  end

  always @(posedge clk_i) begin : event_check
    out_word_t got;
    out_word_t want;
    if (rst_ni && event_if.valid === 1'b1 && event_if.ready === 1'b1) begin
      got = event_if.data;
      if (pending_events.size() == 0) begin
        log_fault("unexpected word, event_time_us", got.event_time_us, '0);
      end else begin
        want = pending_events.pop_front();
        if (got.event_class !== want.event_class)
          log_fault("event_class", 32'(got.event_class), 32'(want.event_class));
        if (got.event_time_us !== want.event_time_us)
          log_fault("event_time_us", got.event_time_us, want.event_time_us);
        if (got.confidence !== want.confidence)
          log_fault("confidence", 32'(got.confidence), 32'(want.confidence));
        if (got.strength !== want.strength)
          log_fault("strength", 32'(got.strength), 32'(want.strength));
      end
    end
  end

  always @(posedge clk_i) begin : watchdog
    if ((hop_if.valid === 1'b1 && hop_if.ready === 1'b1) ||
        (event_if.valid === 1'b1 && event_if.ready === 1'b1)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= STALL_LIMIT) begin
      $display("percussion_onset_gate_test failed");
      $finish;
    end
  end

endmodule
